>>> hw/rtl/tsom_pkg.sv
// Shared types and codes for the three-stack shared-memory block.
`default_nettype none
package tsom_pkg;

    localparam int DEPTH_PER_STACK = 64;
    localparam int STACK_COUNT     = 3;

    typedef logic        [1:0]  op_t;
    typedef logic        [1:0]  sid_t;
    typedef logic        [1:0]  status_t;
    typedef logic signed [31:0] word_t;

    localparam op_t OP_PUSH = 2'd0;
    localparam op_t OP_POP  = 2'd1;
    localparam op_t OP_PEEK = 2'd2;

    localparam status_t STATUS_OK     = 2'd0;
    localparam status_t STATUS_BAD_ID = 2'd1;
    localparam status_t STATUS_FULL   = 2'd2;
    localparam status_t STATUS_EMPTY  = 2'd3;

endpackage
`default_nettype wire

>>> hw/rtl/three_stacks_one_memory.sv
// Three LIFO stacks sharing one synchronous memory, with fill counts in flops.
// Push and refused requests give a registered result the cycle after acceptance;
// a successful pop or peek reads memory into a register, then loads the output.
// One push per cycle while out_ready is high; a pop or peek holds off new
// requests until its read data has reached the output register.
// Reset clears the fill counts and the output valid flag; memory contents and the output payload are not cleared.
`default_nettype none
module three_stacks_one_memory #(
    parameter int DEPTH_PER_STACK = tsom_pkg::DEPTH_PER_STACK
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire tsom_pkg::op_t    req_type,
    input  wire tsom_pkg::sid_t   stack_id,
    input  wire tsom_pkg::word_t  push_value,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output tsom_pkg::status_t     status,
    output tsom_pkg::word_t       read_value,
    output logic                  now_empty
);
    import tsom_pkg::*;

    localparam int STORE_WORDS = STACK_COUNT * DEPTH_PER_STACK;
    localparam int CNT_W       = $clog2(DEPTH_PER_STACK + 1);
    localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg [STACK_COUNT];
    logic              out_valid_reg;
    status_t           out_status_reg;
    word_t             out_value_reg;
    logic              out_empty_reg;
    logic              pend_empty_reg;
    word_t             rd_data_reg;
    word_t             mem [STORE_WORDS];

    logic              in_fire;
    logic              sid_ok;
    logic [CNT_W-1:0]  cur_cnt;
    logic [CNT_W-1:0]  cnt_next;
    logic              is_push;
    logic              do_write;
    logic              do_read;
    status_t           res_status;
    logic              res_empty;
    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] mem_addr;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign read_value = out_value_reg;
    assign now_empty = out_empty_reg;

    always_comb
    begin
        case (stack_id)
            2'd0:    cur_cnt = cnt_reg[0];
            2'd1:    cur_cnt = cnt_reg[1];
            2'd2:    cur_cnt = cnt_reg[2];
            default: cur_cnt = '0;
        endcase
    end

    assign sid_ok    = (stack_id != 2'd3);
    assign is_push   = (req_type == OP_PUSH);
    assign base_addr = ADDR_W'(ADDR_W'(stack_id) * ADDR_W'(DEPTH_PER_STACK));
    // Push writes at the count, reads take the word just below it.
    assign mem_addr  = base_addr + ADDR_W'(cur_cnt) - ADDR_W'(!is_push);

    always_comb
    begin
        res_status = STATUS_OK;
        cnt_next   = cur_cnt;
        do_write   = 1'b0;
        do_read    = 1'b0;
        if (!sid_ok) begin
            res_status = STATUS_BAD_ID;
        end else if (is_push) begin
            if (cur_cnt == CNT_W'(DEPTH_PER_STACK)) begin
                res_status = STATUS_FULL;
            end else begin
                do_write = 1'b1;
                cnt_next = cur_cnt + CNT_W'(1);
            end
        end else if (cur_cnt == '0) begin
            res_status = STATUS_EMPTY;
        end else begin
            do_read = 1'b1;
            if (req_type == OP_POP) begin
                cnt_next = cur_cnt - CNT_W'(1);
            end
        end
        res_empty = sid_ok && (cnt_next == '0);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && do_read) begin
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < STACK_COUNT; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (in_fire && sid_ok) begin
                cnt_reg[stack_id] <= cnt_next;
            end
            if (state_reg == S_READ) begin
                out_valid_reg <= 1'b1;
            end else if (in_fire && !do_read) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output word and pending flags: payload only, no reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ) begin
            out_status_reg <= STATUS_OK;
            out_value_reg  <= rd_data_reg;
            out_empty_reg  <= pend_empty_reg;
        end else if (in_fire) begin
            out_status_reg <= res_status;
            out_value_reg  <= '0;
            out_empty_reg  <= res_empty;
        end
        if (in_fire) begin
            pend_empty_reg <= res_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && do_write) begin
            mem[mem_addr] <= push_value;
        end
        if (in_fire && do_read) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg[0] <= CNT_W'(DEPTH_PER_STACK)) && (cnt_reg[1] <= CNT_W'(DEPTH_PER_STACK))
        && (cnt_reg[2] <= CNT_W'(DEPTH_PER_STACK)))
        else $error("fill count beyond stack depth");

    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> !out_valid_reg && !in_ready)
        else $error("read completion collides with a held result");

    a_bad_id_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == STATUS_BAD_ID) |->
        (!out_empty_reg && out_value_reg == '0))
        else $error("invalid stack result carries data");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && do_write && stack_id == 2'd0) |=>
        (cnt_reg[0] == $past(cur_cnt) + CNT_W'(1)))
        else $error("push did not advance fill count");

    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && do_read) |=> (state_reg == S_READ) ##1 out_valid_reg)
        else $error("read result not delivered");

endmodule
`default_nettype wire
